>>> src/xmlesc_pkg.sv
package xmlesc_pkg;

  localparam int unsigned CpWidth  = 31;
  localparam int unsigned IdxWidth = 4;
  localparam int unsigned NibCount = 8;

  typedef logic [CpWidth-1:0]  cp_t;
  typedef logic [IdxWidth-1:0] idx_t;
  typedef logic [6:0]          ascii_t;

  typedef enum logic [1:0] {
    CtxText = 2'd0,
    CtxAttr = 2'd1,
    CtxCmnt = 2'd2,
    CtxRsvd = 2'd3
  } ctx_e;

  typedef enum logic [2:0] {
    KPlain,
    KLt,
    KGt,
    KAmp,
    KQuot,
    KNum
  } kind_e;

  localparam ascii_t ChAmp  = 7'h26;
  localparam ascii_t ChHash = 7'h23;
  localparam ascii_t ChX    = 7'h78;
  localparam ascii_t ChSemi = 7'h3B;
  localparam ascii_t ChLt   = 7'h3C;
  localparam ascii_t ChGt   = 7'h3E;
  localparam ascii_t ChQuot = 7'h22;
  localparam ascii_t ChL    = 7'h6C;
  localparam ascii_t ChG    = 7'h67;
  localparam ascii_t ChT    = 7'h74;
  localparam ascii_t ChA    = 7'h61;
  localparam ascii_t ChM    = 7'h6D;
  localparam ascii_t ChP    = 7'h70;
  localparam ascii_t ChQ    = 7'h71;
  localparam ascii_t ChU    = 7'h75;
  localparam ascii_t ChO    = 7'h6F;
  localparam ascii_t Ch0    = 7'h30;
  localparam ascii_t ChTab  = 7'h09;
  localparam ascii_t ChLf   = 7'h0A;
  localparam ascii_t ChCr   = 7'h0D;

  localparam cp_t SurLo   = 31'h0000_D800;
  localparam cp_t SurHi   = 31'h0000_DFFF;
  localparam cp_t NonChLo = 31'h0000_FFFE;
  localparam cp_t NonChHi = 31'h0000_FFFF;
  localparam cp_t CpLimit = 31'h0011_0000;
  localparam cp_t CtlMax  = 31'h0000_001F;

  function automatic idx_t named_len(kind_e k);
    idx_t len;
    unique case (k)
      KLt, KGt: len = idx_t'(4);
      KAmp:     len = idx_t'(5);
      KQuot:    len = idx_t'(6);
      default:  len = idx_t'(1);
    endcase
    return len;
  endfunction

  function automatic ascii_t named_char(kind_e k, idx_t idx);
    ascii_t c;
    c = ChSemi;
    if (idx == idx_t'(0)) begin
      c = ChAmp;
    end else begin
      unique case (k)
        KLt: begin
          if (idx == idx_t'(1)) c = ChL;
          else if (idx == idx_t'(2)) c = ChT;
        end
        KGt: begin
          if (idx == idx_t'(1)) c = ChG;
          else if (idx == idx_t'(2)) c = ChT;
        end
        KAmp: begin
          if (idx == idx_t'(1)) c = ChA;
          else if (idx == idx_t'(2)) c = ChM;
          else if (idx == idx_t'(3)) c = ChP;
        end
        KQuot: begin
          if (idx == idx_t'(1)) c = ChQ;
          else if (idx == idx_t'(2)) c = ChU;
          else if (idx == idx_t'(3)) c = ChO;
          else if (idx == idx_t'(4)) c = ChT;
        end
        default: c = ChSemi;
      endcase
    end
    return c;
  endfunction

  function automatic ascii_t hex_char(logic [3:0] nib);
    ascii_t c;
    if (nib < 4'd10) c = Ch0 + ascii_t'(nib);
    else c = ChA + ascii_t'(nib - 4'd10);
    return c;
  endfunction

endpackage

>>> src/xml_character_escaper.sv
// XML character escaper: one code point per start, one output character per
// valid_o cycle, last_o marking the final character of each item. The
// receiver cannot stall. Items pass through a three-stage front end
// (input register, classify, emitter) and an output register, in that order,
// before the first character appears. A plain character is emitted as a
// single character; an escaped one holds the emitter for its whole run (a
// named entity or a hexadecimal numeric reference), and busy_o is raised
// while the front stages back up behind it.
module xml_character_escaper
  import xmlesc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 escape_control_we_i,
  input  logic                 escape_control_i,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [CpWidth-1:0]   code_point_i,
  input  logic [1:0]           context_req_i,
  output logic                 valid_o,
  output logic [CpWidth-1:0]   out_char_o,
  output logic                 last_o
);

  logic esc_ctl_q;

  logic  s1_valid_q;
  cp_t   s1_cp_q;
  ctx_e  s1_ctx_q;

  logic  s2_valid_q;
  kind_e s2_kind_q;
  cp_t   s2_cp_q;
  idx_t  s2_ndig_q;

  logic         em_valid_q;
  kind_e        em_kind_q;
  cp_t          em_cp_q;
  logic [31:0]  em_dig_q;
  idx_t         em_idx_q;
  idx_t         em_len_q;

  logic  out_valid_q;
  cp_t   out_char_q;
  logic  out_last_q;

  logic  em_last, em_free, s2_free, accept;
  kind_e kind_d;
  idx_t  ndig_d;
  cp_t   em_char;
  idx_t  sh;
  logic [31:0] aligned;

  assign em_last = em_idx_q == (em_len_q - idx_t'(1));
  assign em_free = !em_valid_q || em_last;
  assign s2_free = !s2_valid_q || em_free;
  assign busy_o  = s1_valid_q && !s2_free;
  assign accept  = start_i && !busy_o;

  // classify
  always_comb begin
    logic bad, ctl, low;
    logic [31:0] cp_w;
    bad = (s1_cp_q >= SurLo && s1_cp_q <= SurHi) ||
          (s1_cp_q >= NonChLo && s1_cp_q <= NonChHi) || (s1_cp_q >= CpLimit);
    low = s1_cp_q <= CtlMax;
    ctl = s1_cp_q == cp_t'(ChTab) || s1_cp_q == cp_t'(ChLf) ||
          s1_cp_q == cp_t'(ChCr);
    kind_d = KPlain;
    if (s1_cp_q == cp_t'(ChLt)) begin
      kind_d = KLt;
    end else if (s1_cp_q == cp_t'(ChGt)) begin
      kind_d = KGt;
    end else begin
      unique case (s1_ctx_q)
        CtxCmnt: kind_d = KPlain;
        CtxAttr: begin
          if (s1_cp_q == cp_t'(ChQuot)) kind_d = KQuot;
          else if (s1_cp_q == cp_t'(ChAmp)) kind_d = KAmp;
          else if (low || bad) kind_d = KNum;
        end
        default: begin
          if (s1_cp_q == cp_t'(ChAmp)) kind_d = KAmp;
          else if ((low && !ctl) || bad || (ctl && esc_ctl_q)) kind_d = KNum;
        end
      endcase
    end
    cp_w   = {1'b0, s1_cp_q};
    ndig_d = idx_t'(1);
    for (int i = 0; i < NibCount; i++) begin
      if (cp_w[4*i +: 4] != 4'd0) ndig_d = idx_t'(i + 1);
    end
  end

  assign sh      = idx_t'(NibCount) - s2_ndig_q;
  assign aligned = {1'b0, s2_cp_q} << {sh, 2'b00};

  always_comb begin
    em_char = em_cp_q;
    if (em_kind_q == KNum) begin
      if (em_idx_q == idx_t'(0)) em_char = cp_t'(ChAmp);
      else if (em_idx_q == idx_t'(1)) em_char = cp_t'(ChHash);
      else if (em_idx_q == idx_t'(2)) em_char = cp_t'(ChX);
      else if (em_last) em_char = cp_t'(ChSemi);
      else em_char = cp_t'(hex_char(em_dig_q[31:28]));
    end else if (em_kind_q != KPlain) begin
      em_char = cp_t'(named_char(em_kind_q, em_idx_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_ctl_q   <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      em_valid_q  <= 1'b0;
      em_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (escape_control_we_i) esc_ctl_q <= escape_control_i;
      if (!busy_o) s1_valid_q <= accept;
      if (s2_free) s2_valid_q <= s1_valid_q;
      if (em_free) begin
        em_valid_q <= s2_valid_q;
        em_idx_q   <= '0;
      end else begin
        em_idx_q <= em_idx_q + idx_t'(1);
      end
      out_valid_q <= em_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cp_q  <= code_point_i;
      s1_ctx_q <= ctx_e'(context_req_i);
    end
    if (s2_free) begin
      s2_kind_q <= kind_d;
      s2_cp_q   <= s1_cp_q;
      s2_ndig_q <= ndig_d;
    end
    if (em_free) begin
      em_kind_q <= s2_kind_q;
      em_cp_q   <= s2_cp_q;
      em_dig_q  <= aligned;
      em_len_q  <= (s2_kind_q == KNum) ? s2_ndig_q + idx_t'(4) : named_len(s2_kind_q);
    end else if (em_kind_q == KNum && em_idx_q >= idx_t'(3)) begin
      em_dig_q <= {em_dig_q[27:0], 4'd0};
    end
    out_char_q <= em_char;
    out_last_q <= em_last;
  end

  assign valid_o    = out_valid_q;
  assign out_char_o = out_char_q;
  assign last_o     = out_last_q;

endmodule
